[design/sdld_pkg.sv]
// Shared types, constants and segment tables for the two-digit LED driver.
package sdld_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned SCALE_W  = 10;
  localparam int unsigned PROD_W   = BYTE_W + SCALE_W;
  localparam int unsigned VALUE_W  = 10;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned EN_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SCALE_W;
  localparam int unsigned M_TDATA_W  = 32;

  localparam logic [TICK_W-1:0]  TIMEOUT_RST    = 8'd16;
  localparam logic [SCALE_W-1:0] FULL_SCALE_RST = 10'd150;
  localparam logic [VALUE_W-1:0] MAX_SHOWN      = 10'd999;
  localparam logic [DIGIT_W-1:0] E_INDEX        = 4'd10;
  localparam logic [7:0]         DP_BIT         = 8'h02;
  localparam logic [EN_W-1:0]    EN_FIRST       = 2'b01;
  localparam logic [EN_W-1:0]    EN_SECOND      = 2'b10;
  localparam logic [EN_W-1:0]    EN_BOTH        = 2'b11;

  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_ADDR    = 2'd1,
    OP_TICK    = 2'd2,
    OP_REFRESH = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT    = 2'd0,
    CFG_FULL_SCALE = 2'd1
  } cfg_idx_e;

  // Display control that rides along with the value through the pipe.
  typedef struct packed {
    logic phase;
    logic err;
  } disp_ctl_t;

  typedef struct packed {
    logic [7:0]      port_a;
    logic [7:0]      port_b;
    logic [EN_W-1:0] enable;
  } seg_out_t;

  // Port A pattern per digit; index ten is the letter E.
  function automatic logic [7:0] seg_a(input logic [DIGIT_W-1:0] d);
    logic [7:0] r;
    case (d)
      4'd0:    r = 8'hC0;
      4'd1:    r = 8'h00;
      4'd2:    r = 8'h41;
      4'd3:    r = 8'h01;
      4'd4:    r = 8'h81;
      4'd5:    r = 8'h81;
      4'd6:    r = 8'hC1;
      4'd7:    r = 8'h00;
      4'd8:    r = 8'hC1;
      4'd9:    r = 8'h81;
      default: r = 8'hC1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] seg_b(input logic [DIGIT_W-1:0] d);
    logic [7:0] r;
    case (d)
      4'd0:    r = 8'hE4;
      4'd1:    r = 8'h60;
      4'd2:    r = 8'hA4;
      4'd3:    r = 8'hE4;
      4'd4:    r = 8'h60;
      4'd5:    r = 8'hC4;
      4'd6:    r = 8'hC4;
      4'd7:    r = 8'h64;
      4'd8:    r = 8'hE4;
      4'd9:    r = 8'hE4;
      default: r = 8'h84;
    endcase
    return r;
  endfunction

endpackage

[design/scaled_two_digit_led_driver_unit.sv]
// Top level of the scaled two-digit seven-segment LED driver.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  s_axis    | tvalid / tready        | tdata: data_byte; tuser: op
//  m_axis    | tvalid / tready        | tdata: port_a, port_b, enable, value;
//            |                        | tuser: error_shown
//  cfg       | cfg_we_i (no wait)     | cfg_idx_i, cfg_data_i
//
// One item is taken per cycle while the output side is not stalled; its result
// passes the registered multiply, divide-by-255 and encode stages in that order.
// State is updated at the transfer, so back-to-back items see each other's effects.
// Reset clears state, restores register defaults and empties the pipe.
// Each stage advances when the one after it is empty or advancing, so an
// output stall fills the bubbles before the input side is held.
module scaled_two_digit_led_driver_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]                        s_axis_tuser,  // [1:0] op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] port_a_bits, [15:8] port_b_bits, [17:16] digit_enable,
  // [27:18] scaled_value, [31:28] zero
  output logic [sdld_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tuser,  // [0] error_shown
  input  logic                              cfg_we_i,
  input  logic [sdld_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sdld_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sdld_pkg::*;

  // Configuration registers.
  logic [TICK_W-1:0]  timeout_q;
  logic [SCALE_W-1:0] full_scale_q;

  // Architectural state.
  logic [BYTE_W-1:0]  last_byte_q, last_byte_d;
  logic [TICK_W-1:0]  idle_q, idle_d;
  logic               phase_q;

  // Pipe stages.
  logic               s1_valid_q, s2_valid_q, out_valid_q;
  logic [PROD_W-1:0]  s1_prod_q;
  disp_ctl_t          s1_ctl_q, s2_ctl_q;
  logic [VALUE_W-1:0] s2_value_q, out_value_q;
  seg_out_t           out_seg_q, seg_d;
  logic               out_err_q;

  logic s1_ready, s2_ready, out_ready, in_xfer;
  op_e  op;

  assign op        = op_e'(s_axis_tuser);
  assign out_ready = !out_valid_q || m_axis_tready;
  assign s2_ready  = !s2_valid_q || out_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign in_xfer   = s_axis_tvalid && s1_ready;

  // Apply the op to the state; the result uses the updated state.
  always_comb begin
    last_byte_d = last_byte_q;
    idle_d      = idle_q;
    case (op)
      OP_DATA: begin
        last_byte_d = s_axis_tdata;
        idle_d      = '0;
      end
      OP_ADDR: idle_d = '0;
      OP_TICK: begin
        // Saturate at the timeout.
        if (idle_q < timeout_q) idle_d = idle_q + 8'd1;
      end
      default: ;
    endcase
  end

  // Divide by 255: estimate with x*257>>16 (never more than one low),
  // then correct with one compare and add.
  logic [PROD_W+8:0]  prod_x257;
  logic [10:0]        q_est, q_fix;
  logic [PROD_W-1:0]  rem;
  logic [VALUE_W-1:0] value_d;

  assign prod_x257 = {1'b0, s1_prod_q, 8'h00} + (PROD_W+9)'(s1_prod_q);
  assign q_est     = prod_x257[PROD_W+8:16];
  assign rem       = s1_prod_q - PROD_W'({q_est, 8'h00}) + PROD_W'(q_est);
  assign q_fix     = q_est + ((rem >= PROD_W'(255)) ? 11'd1 : 11'd0);
  assign value_d   = (q_fix > 11'(MAX_SHOWN)) ? MAX_SHOWN : q_fix[VALUE_W-1:0];

  sdld_seg_enc u_seg_enc (
    .value_i (s2_value_q),
    .ctl_i   (s2_ctl_q),
    .seg_o   (seg_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TIMEOUT_RST;
      full_scale_q <= FULL_SCALE_RST;
      last_byte_q  <= '0;
      idle_q       <= '0;
      phase_q      <= 1'b0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TIMEOUT:    timeout_q    <= cfg_data_i[TICK_W-1:0];
          CFG_FULL_SCALE: full_scale_q <= cfg_data_i;
          default: ;  // drop writes beyond the register list
        endcase
      end
      if (in_xfer) begin
        last_byte_q <= last_byte_d;
        idle_q      <= idle_d;
        // Advance the refresh phase after this result's phase is captured.
        if (op == OP_REFRESH) phase_q <= !phase_q;
      end
      if (s1_ready) s1_valid_q  <= s_axis_tvalid;
      if (s2_ready) s2_valid_q  <= s1_valid_q;
      if (out_ready) out_valid_q <= s2_valid_q;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_prod_q      <= PROD_W'(last_byte_d) * PROD_W'(full_scale_q);
      s1_ctl_q.phase <= phase_q;
      s1_ctl_q.err   <= (idle_d >= timeout_q);
    end
    if (s2_ready && s1_valid_q) begin
      s2_value_q <= value_d;
      s2_ctl_q   <= s1_ctl_q;
    end
    if (out_ready && s2_valid_q) begin
      out_seg_q   <= seg_d;
      out_err_q   <= s2_ctl_q.err;
      out_value_q <= s2_value_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_err_q;
  assign m_axis_tdata  = {4'h0, out_value_q, out_seg_q.enable,
                          out_seg_q.port_b, out_seg_q.port_a};

  // The error display lights both digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[17:16] == EN_BOTH)
    else $error("error display without both digit enables");

  // A normal display lights exactly one digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> $onehot(m_axis_tdata[17:16]))
    else $error("normal display must enable exactly one digit");

  // The shown value saturates at 999.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> s2_value_q <= MAX_SHOWN)
    else $error("scaled value above display range");

  // The idle count never passes the timeout through a tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && op == OP_TICK && idle_q < timeout_q |=> idle_q <= $past(timeout_q))
    else $error("idle count overran the timeout");

endmodule

[design/sdld_seg_enc.sv]
// Digit split and segment encoding for one display refresh.
module sdld_seg_enc (
  input  logic [sdld_pkg::VALUE_W-1:0] value_i,
  input  sdld_pkg::disp_ctl_t          ctl_i,
  output sdld_pkg::seg_out_t           seg_o
);
  import sdld_pkg::*;

  logic [17:0]        tenth_prod;
  logic [15:0]        hund_prod;
  logic [6:0]         quot10;
  logic [DIGIT_W-1:0] hund, tens, ones, digit;
  logic               dp;

  // v/10 = (v*205)>>11 and v/100 = (v*41)>>12, exact below 1000.
  assign tenth_prod = 18'(value_i) * 18'd205;
  assign hund_prod  = 16'(value_i) * 16'd41;
  assign quot10     = tenth_prod[17:11];
  assign hund       = hund_prod[15:12];
  assign tens       = DIGIT_W'(quot10 - 7'(hund) * 7'd10);
  assign ones       = DIGIT_W'(value_i - 10'(quot10) * 10'd10);

  always_comb begin
    if (value_i < 10'd100) begin
      digit = ctl_i.phase ? tens : ones;
      dp    = ctl_i.phase;
    end else begin
      digit = ctl_i.phase ? hund : tens;
      dp    = !ctl_i.phase;
    end
    if (ctl_i.err) begin
      seg_o.port_a = seg_a(E_INDEX) | DP_BIT;
      seg_o.port_b = seg_b(E_INDEX);
      seg_o.enable = EN_BOTH;
    end else begin
      seg_o.port_a = seg_a(digit) | (dp ? DP_BIT : 8'h00);
      seg_o.port_b = seg_b(digit);
      seg_o.enable = ctl_i.phase ? EN_SECOND : EN_FIRST;
    end
  end

endmodule
